### src/q8sf_pkg.sv
// ----------------------------------------------------------------------------
// q8sf_pkg
// Types and codes shared by the serendipity quad8 shape function evaluator.
// ----------------------------------------------------------------------------
package q8sf_pkg;

  // element node numbers: corners then edge midpoints
  localparam logic [2:0] NODE_C0 = 3'd0;
  localparam logic [2:0] NODE_C1 = 3'd1;
  localparam logic [2:0] NODE_C2 = 3'd2;
  localparam logic [2:0] NODE_C3 = 3'd3;
  localparam logic [2:0] NODE_E4 = 3'd4;
  localparam logic [2:0] NODE_E5 = 3'd5;
  localparam logic [2:0] NODE_E6 = 3'd6;
  localparam logic [2:0] NODE_E7 = 3'd7;

  // derivative direction
  localparam logic DIR_R = 1'b0;
  localparam logic DIR_S = 1'b1;

  // how the derivative is finished after the multiplier stage
  typedef enum logic [1:0] {
    DER_CORNER = 2'd0,  // product shifted by frac + 2
    DER_EDGE   = 2'd1,  // product shifted by frac
    DER_SQ_POS = 2'd2,  // (one - square) / 2
    DER_SQ_NEG = 2'd3   // (square - one) / 2
  } der_kind_t;

  typedef struct packed {
    logic      corner;
    der_kind_t der_kind;
  } q8sf_ctl_t;

  typedef struct packed {
    logic [2:0]         node_index;
    logic               deriv_dir;
    logic signed [15:0] r_coord;
    logic signed [15:0] s_coord;
  } q8sf_req_t;

  typedef struct packed {
    logic signed [15:0] shape_value;
    logic signed [15:0] shape_deriv;
  } q8sf_result_t;

endpackage

### src/quad8_shape_function_eval_top.sv
// ----------------------------------------------------------------------------
// quad8_shape_function_eval_top
// An accepted request passes the stage registers v1, v2 and v3, then done.
// Throughput: one request per cycle, set by the two registered multiplier
// stages (operand product, then product by the third factor).
// Reset: synchronous, clears the stage valid bits; busy is high during reset.
// Results are presented for one cycle only; the receiver cannot stall.
// ----------------------------------------------------------------------------
module quad8_shape_function_eval_top #(
  parameter int FRAC_BITS = 14
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   start,
  output logic                   busy,
  input  q8sf_pkg::q8sf_req_t    req,
  output logic                   done,
  output q8sf_pkg::q8sf_result_t result
);
  import q8sf_pkg::*;

  // operand width holds +-8 in fixed point; clamp width also holds a raw input
  localparam int W  = FRAC_BITS + 4;
  localparam int PW = 2 * W;
  localparam int XW = (W > 17) ? W : 17;
  localparam logic signed [W-1:0]  ONE  = W'(1) << FRAC_BITS;
  localparam logic signed [XW-1:0] ONEX = XW'(1) << FRAC_BITS;
  localparam logic signed [PW-1:0] SMAX = PW'(32767);
  localparam logic signed [PW-1:0] SMIN = -PW'(32768);

  function automatic logic signed [15:0] sat16(input logic signed [PW-1:0] v);
    if (v > SMAX) begin
      return 16'sh7fff;
    end else if (v < SMIN) begin
      return 16'sh8000;
    end else begin
      return v[15:0];
    end
  endfunction

  // the block never holds a request off outside reset
  assign busy = rst;

  // ---------------- stage 1: clamp coordinates to [-one, one] --------------
  logic signed [XW-1:0] rx;
  logic signed [XW-1:0] sx;
  logic signed [XW-1:0] rc;
  logic signed [XW-1:0] sc;

  always_comb begin
    rx = XW'(req.r_coord);
    sx = XW'(req.s_coord);
    rc = (rx > ONEX) ? ONEX : ((rx < -ONEX) ? -ONEX : rx);
    sc = (sx > ONEX) ? ONEX : ((sx < -ONEX) ? -ONEX : sx);
  end

  logic                v1;
  logic [2:0]          node1;
  logic                dir1;
  logic signed [W-1:0] r1;
  logic signed [W-1:0] s1;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else begin
      v1 <= start && !busy;
    end
    node1 <= req.node_index;
    dir1  <= req.deriv_dir;
    r1    <= rc[W-1:0];
    s1    <= sc[W-1:0];
  end

  // ---------------- stage 2: operand selection and first products ----------
  logic signed [W-1:0] mul_a;
  logic signed [W-1:0] mul_b;
  logic signed [W-1:0] third;
  logic signed [W-1:0] der_a;
  logic signed [W-1:0] der_b;
  q8sf_ctl_t           ctl;

  q8sf_factors #(
    .FRAC_BITS (FRAC_BITS)
  ) u_factors (
    .node_index (node1),
    .deriv_dir  (dir1),
    .r          (r1),
    .s          (s1),
    .mul_a      (mul_a),
    .mul_b      (mul_b),
    .third      (third),
    .der_a      (der_a),
    .der_b      (der_b),
    .ctl        (ctl)
  );

  logic                 v2;
  q8sf_ctl_t            ctl2;
  logic signed [PW-1:0] p1;
  logic signed [PW-1:0] pd;
  logic signed [W-1:0]  third2;

  always_ff @(posedge clk) begin
    if (rst) begin
      v2 <= 1'b0;
    end else begin
      v2 <= v1;
    end
    ctl2   <= ctl;
    p1     <= PW'(mul_a) * PW'(mul_b);   // corner pair product or square
    pd     <= PW'(der_a) * PW'(der_b);   // derivative product
    third2 <= third;
  end

  // ---------------- stage 3: second product, derivative finish -------------
  logic signed [PW-1:0] p1_sh;
  logic signed [W-1:0]  q;
  logic signed [W-1:0]  m3a;
  logic signed [W-1:0]  one_m_q;
  logic signed [W-1:0]  q_m_one;
  logic signed [PW-1:0] der_wide;

  always_comb begin
    p1_sh   = p1 >>> FRAC_BITS;
    q       = p1_sh[W-1:0];
    one_m_q = ONE - q;
    q_m_one = q - ONE;
    // corners reuse the truncated pair product; edges take one minus square
    m3a     = ctl2.corner ? q : one_m_q;
    case (ctl2.der_kind)
      DER_CORNER: der_wide = pd >>> (FRAC_BITS + 2);
      DER_EDGE:   der_wide = pd >>> FRAC_BITS;
      DER_SQ_POS: der_wide = PW'(one_m_q >>> 1);
      DER_SQ_NEG: der_wide = PW'(q_m_one >>> 1);
      default:    der_wide = '0;
    endcase
  end

  logic                 v3;
  logic                 corner3;
  logic signed [PW-1:0] p2;
  logic signed [15:0]   der3;

  always_ff @(posedge clk) begin
    if (rst) begin
      v3 <= 1'b0;
    end else begin
      v3 <= v2;
    end
    corner3 <= ctl2.corner;
    p2      <= PW'(m3a) * PW'(third2);
    der3    <= sat16(der_wide);
  end

  // ---------------- stage 4: final scale, saturate, present ----------------
  logic signed [PW-1:0] val_wide;

  always_comb begin
    // corners divide by 4, edge midpoints by 2
    val_wide = corner3 ? (p2 >>> (FRAC_BITS + 2)) : (p2 >>> (FRAC_BITS + 1));
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= v3;
    end
    result.shape_value <= sat16(val_wide);
    result.shape_deriv <= der3;
  end

endmodule

### src/q8sf_factors.sv
// ----------------------------------------------------------------------------
// q8sf_factors
// Picks the multiplier operands for one node and derivative direction.
// ----------------------------------------------------------------------------
module q8sf_factors #(
  parameter int FRAC_BITS = 14
) (
  input  logic [2:0]                 node_index,
  input  logic                       deriv_dir,
  input  logic signed [FRAC_BITS+3:0] r,
  input  logic signed [FRAC_BITS+3:0] s,
  output logic signed [FRAC_BITS+3:0] mul_a,
  output logic signed [FRAC_BITS+3:0] mul_b,
  output logic signed [FRAC_BITS+3:0] third,
  output logic signed [FRAC_BITS+3:0] der_a,
  output logic signed [FRAC_BITS+3:0] der_b,
  output q8sf_pkg::q8sf_ctl_t         ctl
);
  import q8sf_pkg::*;

  localparam int W = FRAC_BITS + 4;
  localparam logic signed [W-1:0] ONE = W'(1) << FRAC_BITS;

  logic signed [W-1:0] one_p_r;
  logic signed [W-1:0] one_m_r;
  logic signed [W-1:0] one_p_s;
  logic signed [W-1:0] one_m_s;
  logic signed [W-1:0] r2;
  logic signed [W-1:0] s2;

  always_comb begin
    one_p_r = ONE + r;
    one_m_r = ONE - r;
    one_p_s = ONE + s;
    one_m_s = ONE - s;
    r2      = r <<< 1;
    s2      = s <<< 1;
    mul_a   = r;
    mul_b   = r;
    third   = one_m_s;
    der_a   = r;
    der_b   = s;
    ctl     = '{corner: 1'b1, der_kind: DER_CORNER};
    case (node_index)
      NODE_C0: begin
        mul_a = one_m_r;
        mul_b = one_m_s;
        third = -ONE - r - s;
        der_a = (deriv_dir == DIR_S) ? one_m_r : one_m_s;
        der_b = (deriv_dir == DIR_S) ? r + s2 : r2 + s;
      end
      NODE_C1: begin
        mul_a = one_p_r;
        mul_b = one_m_s;
        third = -ONE + r - s;
        der_a = (deriv_dir == DIR_S) ? one_p_r : one_m_s;
        der_b = (deriv_dir == DIR_S) ? s2 - r : r2 - s;
      end
      NODE_C2: begin
        mul_a = one_p_r;
        mul_b = one_p_s;
        third = -ONE + r + s;
        der_a = (deriv_dir == DIR_S) ? one_p_r : one_p_s;
        der_b = (deriv_dir == DIR_S) ? r + s2 : r2 + s;
      end
      NODE_C3: begin
        mul_a = one_m_r;
        mul_b = one_p_s;
        third = -ONE - r + s;
        der_a = (deriv_dir == DIR_S) ? one_m_r : one_p_s;
        der_b = (deriv_dir == DIR_S) ? s2 - r : r2 - s;
      end
      NODE_E4: begin
        // square of r first, then (one - rr)(one - s)
        mul_a = r;
        mul_b = r;
        third = one_m_s;
        der_a = r;
        der_b = s - ONE;
        ctl   = '{corner: 1'b0,
                  der_kind: (deriv_dir == DIR_S) ? DER_SQ_NEG : DER_EDGE};
      end
      NODE_E5: begin
        mul_a = s;
        mul_b = s;
        third = one_p_r;
        der_a = -s;
        der_b = one_p_r;
        ctl   = '{corner: 1'b0,
                  der_kind: (deriv_dir == DIR_S) ? DER_EDGE : DER_SQ_POS};
      end
      NODE_E6: begin
        mul_a = r;
        mul_b = r;
        third = one_p_s;
        der_a = -r;
        der_b = one_p_s;
        ctl   = '{corner: 1'b0,
                  der_kind: (deriv_dir == DIR_S) ? DER_SQ_POS : DER_EDGE};
      end
      default: begin
        mul_a = s;
        mul_b = s;
        third = one_m_r;
        der_a = s;
        der_b = r - ONE;
        ctl   = '{corner: 1'b0,
                  der_kind: (deriv_dir == DIR_S) ? DER_EDGE : DER_SQ_NEG};
      end
    endcase
  end

endmodule

### src/q8sf_checker.sv
// ----------------------------------------------------------------------------
// q8sf_checker
// Port-level checks on request to result timing, a sign property and busy.
// ----------------------------------------------------------------------------
module q8sf_checker (
  input logic                   clk,
  input logic                   rst,
  input logic                   start,
  input logic                   busy,
  input q8sf_pkg::q8sf_req_t    req,
  input logic                   done,
  input q8sf_pkg::q8sf_result_t result
);
  import q8sf_pkg::*;

  // every accepted request is answered by a done strobe
  a_latency: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |-> ##4 done)
    else $error("accepted request got no result after four cycles");

  // no result without a matching earlier request
  a_no_spurious: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(start && !busy, 4))
    else $error("result strobe without a matching request");

  // top edge midpoint: d/ds is (one - r^2)/2, never negative
  a_edge6_sign: assert property (@(posedge clk) disable iff (rst)
    (start && !busy && req.node_index == NODE_E6 && req.deriv_dir == DIR_S)
      |-> ##4 !result.shape_deriv[15])
    else $error("negative d/ds on top edge midpoint");

  // outside reset requests are always taken
  a_not_busy: assert property (@(posedge clk)
    !rst |-> !busy)
    else $error("busy outside reset");

endmodule

bind quad8_shape_function_eval_top q8sf_checker u_q8sf_checker (.*);
